// ===== rtl/core/kra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kra_pkg: shared types and constants for the keyboard report aggregator
// Opcodes, result kinds, report field widths and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package kra_pkg;

   localparam int KEY_W      = 8;
   localparam int MASK_W     = 8;
   localparam int COUNT_W    = 8;
   localparam int OPCODE_W   = 3;
   localparam int OUT_SLOTS  = 6;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;

   typedef enum logic [OPCODE_W-1:0] {
      OP_KEY_PRESS   = 3'd0,
      OP_KEY_RELEASE = 3'd1,
      OP_MOD_PRESS   = 3'd2,
      OP_MOD_RELEASE = 3'd3,
      OP_SEND        = 3'd4,
      OP_QUERY       = 3'd5
   } opcode_type;

   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef enum logic [1:0] {
      OUT_SENT  = 2'd0,
      OUT_HELD  = 2'd1,
      OUT_QUERY = 2'd2
   } out_sel_type;

   typedef struct packed {
      logic        accept;
      logic        rd_key;
      logic        upd_key;
      logic        upd_mod;
      logic        commit_sent;
      logic        load_out;
      out_sel_type out_sel;
      logic        out_last;
   } cmd_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic                key_ok;
      logic                changed;
      logic                both_added;
      logic                report_enable;
      logic                out_free;
   } sts_type;

endpackage

// ===== rtl/core/kra_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kra_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/kra_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kra_datapath: counters, key table and report register
// Holds the item register, key count RAM with valid bits, held and sent key
// tables, modifier counters, the enable register and the result register.
// ----------------------------------------------------------------------------
module kra_datapath #(
   parameter int KEY_SLOTS     = 6,
   parameter int KEY_CODES     = 256,
   parameter int MODIFIER_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [kra_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             csr_valid,
   input  logic                             csr_wdata,
   output logic                             csr_ready,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output logic [kra_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   input  kra_pkg::cmd_type                 cmd,
   output kra_pkg::sts_type                 sts
);

   import kra_pkg::*;

   localparam int CODE_AW = $clog2(KEY_CODES);
   localparam int SLOT_IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

   logic [OPCODE_W-1:0] op_ff;
   logic [KEY_W-1:0]    code_ff;
   logic [MASK_W-1:0]   mask_ff;
   logic                report_enable_ff;

   logic [KEY_CODES-1:0] key_vld_ff;
   logic                 vld_rd_ff;
   logic [COUNT_W-1:0]   ram_rdata;
   logic [COUNT_W-1:0]   count_old;
   logic [COUNT_W-1:0]   count_new;
   logic [CODE_AW-1:0]   key_addr;
   logic                 key_ok;
   logic                 is_press;

   logic [KEY_SLOTS-1:0][KEY_W-1:0] held_ff, held_in;
   logic [KEY_SLOTS-1:0][KEY_W-1:0] sent_ff;
   logic [MASK_W-1:0]               sent_mods_ff;
   logic [KEY_SLOTS-1:0][KEY_W-1:0] press_tbl, release_tbl, press_shift, release_shift;
   logic [(KEY_SLOTS+1)*KEY_W-1:0]  press_cat, release_cat;
   logic                            has_free, found;
   logic [SLOT_IW-1:0]              free_idx, match_idx;

   logic [COUNT_W-1:0] mod_cnt_ff [MODIFIER_BITS];
   logic [COUNT_W-1:0] mod_cnt_in [MODIFIER_BITS];
   logic [MASK_W-1:0]  cur_mods;

   logic keys_changed, keys_added, mods_added;

   logic                                  rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0]                 rsp_data_ff, rsp_data_in;
   logic                                  rsp_kind_ff, rsp_kind_in;
   logic                                  rsp_last_ff;
   logic [KEY_SLOTS-1:0][KEY_W-1:0]       out_tbl;
   logic [(KEY_SLOTS+OUT_SLOTS)*KEY_W-1:0] out_pad;
   logic [OUT_SLOTS*KEY_W-1:0]            out_slots;
   logic [MASK_W-1:0]                     out_mods;
   logic                                  out_held;

   // item register and enable register
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_tdata[OPCODE_W-1:0];
         code_ff <= req_tdata[OPCODE_W+KEY_W-1:OPCODE_W];
         mask_ff <= req_tdata[OPCODE_W+KEY_W+MASK_W-1:OPCODE_W+KEY_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         report_enable_ff <= 1'b1;
      end else if (csr_valid) begin
         report_enable_ff <= csr_wdata;
      end
   end

   assign csr_ready = 1'b1;

   // key count store
   assign key_ok   = ({1'b0, code_ff} < (KEY_W+1)'(KEY_CODES));
   assign key_addr = code_ff[CODE_AW-1:0];
   assign is_press = (op_ff == OP_KEY_PRESS);

   kra_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (KEY_CODES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cmd.upd_key),
      .wr_addr (key_addr),
      .wr_data (count_new),
      .rd_en   (cmd.rd_key),
      .rd_addr (key_addr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         key_vld_ff <= '0;
      end else if (cmd.upd_key) begin
         key_vld_ff[key_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_key) begin
         vld_rd_ff <= key_vld_ff[key_addr];
      end
   end

   assign count_old = vld_rd_ff ? ram_rdata : '0;
   assign count_new = is_press ? count_old + COUNT_W'(1) : count_old - COUNT_W'(1);

   // held key table
   always_comb begin
      has_free  = 1'b0;
      free_idx  = '0;
      found     = 1'b0;
      match_idx = '0;
      for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
         if (held_ff[i] == '0) begin
            has_free = 1'b1;
            free_idx = SLOT_IW'(i);
         end
         if (held_ff[i] == code_ff) begin
            found     = 1'b1;
            match_idx = SLOT_IW'(i);
         end
      end
   end

   assign press_cat     = {code_ff, held_ff};
   assign release_cat   = {{KEY_W{1'b0}}, held_ff};
   assign press_shift   = press_cat[(KEY_SLOTS+1)*KEY_W-1:KEY_W];
   assign release_shift = release_cat[(KEY_SLOTS+1)*KEY_W-1:KEY_W];

   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (has_free) begin
            press_tbl[i] = (SLOT_IW'(i) == free_idx) ? code_ff : held_ff[i];
         end else begin
            press_tbl[i] = press_shift[i];
         end
         release_tbl[i] = (SLOT_IW'(i) < match_idx) ? held_ff[i] : release_shift[i];
      end
   end

   always_comb begin
      held_in = held_ff;
      if (cmd.upd_key && code_ff != '0) begin
         if (is_press && !found) begin
            held_in = press_tbl;
         end else if (!is_press && found && count_new == '0) begin
            held_in = release_tbl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         sent_ff      <= '0;
         sent_mods_ff <= '0;
      end else begin
         held_ff <= held_in;
         if (cmd.commit_sent) begin
            sent_ff      <= held_ff;
            sent_mods_ff <= cur_mods;
         end
      end
   end

   // modifier counters
   always_comb begin
      cur_mods = '0;
      for (int i = 0; i < MODIFIER_BITS; i++) begin
         cur_mods[i] = |mod_cnt_ff[i];
         mod_cnt_in[i] = mod_cnt_ff[i];
         if (cmd.upd_mod && mask_ff[i]) begin
            mod_cnt_in[i] = (op_ff == OP_MOD_PRESS) ? mod_cnt_ff[i] + COUNT_W'(1)
                                                    : mod_cnt_ff[i] - COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MODIFIER_BITS; i++) begin
         if (reset) begin
            mod_cnt_ff[i] <= '0;
         end else begin
            mod_cnt_ff[i] <= mod_cnt_in[i];
         end
      end
   end

   // report comparison
   always_comb begin
      keys_added = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         logic hit;
         hit = 1'b0;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            hit = hit | (sent_ff[j] == held_ff[i]);
         end
         keys_added = keys_added | ((held_ff[i] != '0) && !hit);
      end
   end

   assign keys_changed = (held_ff != sent_ff);
   assign mods_added   = |(cur_mods & ~sent_mods_ff);

   // result register
   always_comb begin
      out_tbl     = held_ff;
      out_mods    = cur_mods;
      out_held    = 1'b0;
      rsp_kind_in = KIND_REPORT;
      case (cmd.out_sel)
         OUT_SENT: begin
            out_tbl = sent_ff;
         end
         OUT_HELD: begin
            out_tbl = held_ff;
         end
         OUT_QUERY: begin
            out_tbl     = '0;
            out_mods    = '0;
            out_held    = |cur_mods;
            rsp_kind_in = KIND_QUERY;
         end
         default: begin
            out_tbl = held_ff;
         end
      endcase
   end

   assign out_pad     = {{(OUT_SLOTS*KEY_W){1'b0}}, out_tbl};
   assign out_slots   = out_pad[OUT_SLOTS*KEY_W-1:0];
   assign rsp_data_in = {{(RSP_DATA_W-MASK_W-OUT_SLOTS*KEY_W-1){1'b0}},
                         out_held, out_slots, out_mods};
   assign rsp_vld_in  = cmd.load_out | (rsp_vld_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_last_ff <= cmd.out_last;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign sts.opcode        = op_ff;
   assign sts.key_ok        = key_ok;
   assign sts.changed       = keys_changed | (cur_mods != sent_mods_ff);
   assign sts.both_added    = keys_added & mods_added;
   assign sts.report_enable = report_enable_ff;
   assign sts.out_free      = ~rsp_vld_ff | rsp_tready;

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_vld_ff)
      else $error("result register not valid after load");

   a_press_in_table: assert property (@(posedge clock) disable iff (reset)
      (cmd.upd_key && is_press && code_ff != '0) |=> found)
      else $error("pressed key missing from held table");

   a_commit_copies: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_sent |=> (sent_ff == $past(held_ff)) && (sent_mods_ff == $past(cur_mods)))
      else $error("sent copy does not match current report");

endmodule

// ===== rtl/core/kra_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kra_ctrl: controller for the keyboard report aggregator
// Accepts one transaction at a time, sequences the count read-modify-write
// and the emission of zero, one or two results.
// ----------------------------------------------------------------------------
module kra_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  kra_pkg::sts_type sts,
   output kra_pkg::cmd_type cmd
);

   import kra_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_DISPATCH   = 6'b000010,
      ST_KEY_UPD    = 6'b000100,
      ST_EMIT_FIRST = 6'b001000,
      ST_EMIT_LAST  = 6'b010000,
      ST_EMIT_QUERY = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.out_sel     = OUT_HELD;
      cmd.accept      = req_tvalid & req_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_IDLE;
            case (sts.opcode)
               OP_KEY_PRESS, OP_KEY_RELEASE: begin
                  if (sts.key_ok) begin
                     cmd.rd_key = 1'b1;
                     state_in   = ST_KEY_UPD;
                  end
               end
               OP_MOD_PRESS, OP_MOD_RELEASE: begin
                  cmd.upd_mod = 1'b1;
               end
               OP_SEND: begin
                  if (sts.changed) begin
                     if (!sts.report_enable) begin
                        cmd.commit_sent = 1'b1;
                     end else if (sts.both_added) begin
                        state_in = ST_EMIT_FIRST;
                     end else begin
                        state_in = ST_EMIT_LAST;
                     end
                  end
               end
               OP_QUERY: begin
                  state_in = ST_EMIT_QUERY;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_KEY_UPD: begin
            cmd.upd_key = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_EMIT_FIRST: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = OUT_SENT;
               state_in     = ST_EMIT_LAST;
            end
         end
         ST_EMIT_LAST: begin
            if (sts.out_free) begin
               cmd.load_out    = 1'b1;
               cmd.out_sel     = OUT_HELD;
               cmd.out_last    = 1'b1;
               cmd.commit_sent = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_EMIT_QUERY: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = OUT_QUERY;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("result register overwritten");

   a_read_then_write: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_key |=> cmd.upd_key)
      else $error("count read not followed by write");

   a_first_then_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && !cmd.out_last) |=> (state_ff == ST_EMIT_LAST))
      else $error("first report not followed by final report");

endmodule

// ===== rtl/core/keyboard_report_aggregator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_report_aggregator_top: six-key rollover keyboard report builder
// Counts key and modifier presses, keeps the held key table and emits
// keyboard reports on change and modifier status answers on request.
//
// Channel   Direction  Handshake                 Payload
// req_      in         req_tvalid / req_tready   req_tdata (opcode, key, mask)
// rsp_      out        rsp_tvalid / rsp_tready   rsp_tdata, rsp_tuser, rsp_tlast
// csr_      in         csr_valid / csr_ready     csr_wdata (report enable)
//
// Key press/release: dispatch, then key update (count RAM read, write-back).
// Modifier press/release and idle opcodes: dispatch only. Send and query:
// dispatch, then any emit states, which wait on the result register; it holds
// one result. Reset clears all key counts at once through per-code valid bits.
// A stalled result blocks only items that produce results and those behind.
// ----------------------------------------------------------------------------
module keyboard_report_aggregator_top #(
   parameter int KEY_SLOTS     = 6,
   parameter int KEY_CODES     = 256,
   parameter int MODIFIER_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [2:0] opcode, [10:3] key_code, [18:11] modifier_mask, [23:19] zero
   input  logic [kra_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] modifier_byte, [15:8] key_slot0 .. [55:48] key_slot5,
   // [56] modifiers_held, [63:57] zero
   output logic [kra_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] result_kind
   output logic                           rsp_tuser,
   output logic                           rsp_tlast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_wdata
);

   import kra_pkg::*;

   cmd_type cmd;
   sts_type sts;

   kra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   kra_datapath #(
      .KEY_SLOTS     (KEY_SLOTS),
      .KEY_CODES     (KEY_CODES),
      .MODIFIER_BITS (MODIFIER_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .csr_ready  (csr_ready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ===== sim/keyboard_report_aggregator_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_report_aggregator_top_test: self-checking bench for the aggregator
// A queue of key, modifier, send and query transactions feeds a clocked
// driver with random gaps. Each accepted transaction updates a local model
// of key counts, held and sent key tables and modifier counters, which
// predicts the reports and status answers. A clocked monitor with random
// back-pressure checks every result field against the oldest prediction.
// The report enable register is toggled between phases.
// ----------------------------------------------------------------------------
module keyboard_report_aggregator_top_test;
   import kra_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;
   localparam int SLOTS          = 6;
   localparam int CODES          = 256;
   localparam int MODS           = 8;
   localparam int SETTLE_CYCLES  = 10;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [OPCODE_W-1:0] op;
      logic [KEY_W-1:0]    key;
      logic [MASK_W-1:0]   mask;
   } kbd_event_type;

   typedef struct {
      logic                        kind;
      logic [MASK_W-1:0]           mods;
      logic [SLOTS-1:0][KEY_W-1:0] slots;
      logic                        held;
      logic                        last;
   } kbd_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic                  csr_wdata;

   keyboard_report_aggregator_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   logic [COUNT_W-1:0]          key_count [CODES];
   logic [COUNT_W-1:0]          mod_count [MODS];
   logic [SLOTS-1:0][KEY_W-1:0] held_slots;
   logic [SLOTS-1:0][KEY_W-1:0] sent_slots;
   logic [MASK_W-1:0]           sent_mods;
   logic                        report_on;

   kbd_event_type  event_queue[$];
   kbd_result_type awaited_results[$];
   kbd_event_type  on_bus;
   int             queued_events;
   int             accepted_events;
   int             failures;
   int             idle_cycles;
   int             req_gap;
   int             rsp_stall;
   bit             req_calm;
   bit             rsp_calm;
   int             gen_key_cnt [CODES];
   int             gen_mod_cnt [MODS];

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [MASK_W-1:0] live_mods();
      logic [MASK_W-1:0] m;
      m = '0;
      for (int i = 0; i < MODS; i++) m[i] = (mod_count[i] != 0);
      return m;
   endfunction

   function automatic bit in_slots(logic [SLOTS-1:0][KEY_W-1:0] t, logic [KEY_W-1:0] code);
      for (int i = 0; i < SLOTS; i++) if (t[i] == code) return 1'b1;
      return 1'b0;
   endfunction

   function automatic kbd_result_type make_report(logic [MASK_W-1:0] mods,
                                                  logic [SLOTS-1:0][KEY_W-1:0] slots,
                                                  logic last);
      kbd_result_type res;
      res.kind  = KIND_REPORT;
      res.mods  = mods;
      res.slots = slots;
      res.held  = 1'b0;
      res.last  = last;
      return res;
   endfunction

   task automatic apply_event(kbd_event_type ev);
      logic [MASK_W-1:0] mods;
      bit                keys_added;
      bit                mods_added;
      int                spot;
      kbd_result_type    res;
      case (ev.op)
         OP_KEY_PRESS: begin
            key_count[ev.key] = key_count[ev.key] + 1'b1;
            if (ev.key != 0 && !in_slots(held_slots, ev.key)) begin
               spot = -1;
               for (int i = SLOTS - 1; i >= 0; i--) if (held_slots[i] == 0) spot = i;
               if (spot >= 0) held_slots[spot] = ev.key;
               else held_slots = {ev.key, held_slots[SLOTS-1:1]};
            end
         end
         OP_KEY_RELEASE: begin
            key_count[ev.key] = key_count[ev.key] - 1'b1;
            if (key_count[ev.key] == 0 && ev.key != 0) begin
               spot = -1;
               for (int i = SLOTS - 1; i >= 0; i--) if (held_slots[i] == ev.key) spot = i;
               if (spot >= 0) begin
                  for (int j = spot; j < SLOTS - 1; j++) held_slots[j] = held_slots[j+1];
                  held_slots[SLOTS-1] = '0;
               end
            end
         end
         OP_MOD_PRESS: begin
            for (int i = 0; i < MODS; i++)
               if (ev.mask[i]) mod_count[i] = mod_count[i] + 1'b1;
         end
         OP_MOD_RELEASE: begin
            for (int i = 0; i < MODS; i++)
               if (ev.mask[i]) mod_count[i] = mod_count[i] - 1'b1;
         end
         OP_SEND: begin
            mods = live_mods();
            if (held_slots != sent_slots || mods != sent_mods) begin
               keys_added = 1'b0;
               for (int i = 0; i < SLOTS; i++)
                  if (held_slots[i] != 0 && !in_slots(sent_slots, held_slots[i]))
                     keys_added = 1'b1;
               mods_added = (mods & ~sent_mods) != 0;
               if (report_on) begin
                  if (keys_added && mods_added) begin
                     awaited_results.push_back(make_report(mods, sent_slots, 1'b0));
                     awaited_results.push_back(make_report(mods, held_slots, 1'b1));
                  end else begin
                     awaited_results.push_back(make_report(mods, held_slots, 1'b1));
                  end
               end
               sent_slots = held_slots;
               sent_mods  = mods;
            end
         end
         OP_QUERY: begin
            res.kind  = KIND_QUERY;
            res.mods  = '0;
            res.slots = '0;
            res.held  = (live_mods() != 0);
            res.last  = 1'b1;
            awaited_results.push_back(res);
         end
         default: begin
         end
      endcase
   endtask

   task automatic queue_event(logic [OPCODE_W-1:0] op, logic [KEY_W-1:0] key,
                              logic [MASK_W-1:0] mask);
      kbd_event_type ev;
      ev.op   = op;
      ev.key  = key;
      ev.mask = mask;
      event_queue.push_back(ev);
      queued_events++;
      if (op == OP_KEY_PRESS) gen_key_cnt[key]++;
      else if (op == OP_KEY_RELEASE) gen_key_cnt[key]--;
      else if (op == OP_MOD_PRESS || op == OP_MOD_RELEASE)
         for (int i = 0; i < MODS; i++)
            if (mask[i]) gen_mod_cnt[i] += (op == OP_MOD_PRESS) ? 1 : -1;
   endtask

   function automatic logic [KEY_W-1:0] press_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return KEY_W'($urandom_range(4, 13));
      if (r < 80) return '0;
      return KEY_W'($urandom);
   endfunction

   function automatic logic [KEY_W-1:0] release_key();
      int down[$];
      int r;
      r = $urandom_range(0, 99);
      for (int c = 0; c < CODES; c++) if (gen_key_cnt[c] > 0) down.push_back(c);
      if (down.size() != 0 && r < 85) return KEY_W'(down[$urandom_range(0, down.size() - 1)]);
      return press_key();
   endfunction

   function automatic logic [MASK_W-1:0] press_mask();
      if ($urandom_range(0, 99) < 70) return MASK_W'(1 << $urandom_range(0, MODS - 1));
      return MASK_W'($urandom);
   endfunction

   function automatic logic [MASK_W-1:0] release_mask();
      int down[$];
      for (int i = 0; i < MODS; i++) if (gen_mod_cnt[i] > 0) down.push_back(i);
      if (down.size() != 0 && $urandom_range(0, 99) < 75)
         return MASK_W'(1 << down[$urandom_range(0, down.size() - 1)]);
      return MASK_W'($urandom);
   endfunction

   task automatic queue_random(int count);
      int r;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 27)      queue_event(OP_KEY_PRESS, press_key(), MASK_W'($urandom));
         else if (r < 55) queue_event(OP_KEY_RELEASE, release_key(), MASK_W'($urandom));
         else if (r < 63) queue_event(OP_MOD_PRESS, KEY_W'($urandom), press_mask());
         else if (r < 71) queue_event(OP_MOD_RELEASE, KEY_W'($urandom), release_mask());
         else if (r < 93) queue_event(OP_SEND, KEY_W'($urandom), MASK_W'($urandom));
         else if (r < 98) queue_event(OP_QUERY, KEY_W'($urandom), MASK_W'($urandom));
         else queue_event($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7,
                          KEY_W'($urandom), MASK_W'($urandom));
      end
   endtask

   task automatic write_enable(logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      report_on = value;
   endtask

   task automatic wait_drained();
      while (accepted_events != queued_events || awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         failures++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_event(on_bus);
            accepted_events++;
         end
         if (!req_tvalid || req_tready) begin
            if ($urandom_range(0, 149) == 0) req_calm = !req_calm;
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (event_queue.size() != 0) begin
               on_bus = event_queue.pop_front();
               req_tdata  <= REQ_DATA_W'({on_bus.mask, on_bus.key, on_bus.op});
               req_tvalid <= 1'b1;
               req_gap = req_calm ? 0 : pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      kbd_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected result: tuser %0b tdata 0x%h tlast %0b",
                      rsp_tuser, rsp_tdata, rsp_tlast);
               failures++;
            end else begin
               want = awaited_results.pop_front();
               check_field("result_kind", want.kind, rsp_tuser);
               check_field("modifier_byte", want.mods, rsp_tdata[7:0]);
               for (int i = 0; i < SLOTS; i++)
                  check_field($sformatf("key_slot%0d", i), want.slots[i],
                              rsp_tdata[8 + 8*i +: 8]);
               check_field("modifiers_held", want.held, rsp_tdata[56]);
               check_field("last_of_run", want.last, rsp_tlast);
            end
         end
         if ($urandom_range(0, 149) == 0) rsp_calm = !rsp_calm;
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!rsp_calm && $urandom_range(0, 3) == 0) rsp_stall = pick_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL keyboard_report_aggregator_top");
         $finish;
      end
   end

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_wdata  = 1'b0;
      for (int c = 0; c < CODES; c++) key_count[c] = '0;
      for (int i = 0; i < MODS; i++) mod_count[i] = '0;
      held_slots = '0;
      sent_slots = '0;
      sent_mods  = '0;
      report_on  = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_enable(1'b1);
      queue_event(OP_KEY_PRESS, 8'h04, 8'h00);
      queue_event(OP_SEND, 8'hff, 8'hff);
      queue_event(OP_MOD_PRESS, 8'h00, 8'h01);
      queue_event(OP_KEY_PRESS, 8'h05, 8'h00);
      // keys and modifiers both added: two reports
      queue_event(OP_SEND, 8'h00, 8'h00);
      queue_event(OP_QUERY, 8'h00, 8'h00);
      queue_event(OP_KEY_PRESS, 8'h00, 8'hff);
      queue_event(OP_SEND, 8'h00, 8'h00);
      for (int k = 6; k <= 9; k++) queue_event(OP_KEY_PRESS, KEY_W'(k), 8'h00);
      // table full: drop the oldest key
      queue_event(OP_KEY_PRESS, 8'hff, 8'h00);
      queue_event(OP_SEND, 8'h00, 8'h00);
      queue_event(OP_KEY_RELEASE, 8'h04, 8'h00);
      queue_event(OP_KEY_RELEASE, 8'h07, 8'h00);
      // release from zero wraps, press wraps back to zero
      queue_event(OP_KEY_RELEASE, 8'h20, 8'h00);
      queue_event(OP_KEY_PRESS, 8'h20, 8'h00);
      queue_event(OP_MOD_PRESS, 8'h00, 8'hff);
      queue_event(OP_MOD_RELEASE, 8'h00, 8'h01);
      queue_event(OP_SEND, 8'h00, 8'h00);
      queue_event(OP_MOD_RELEASE, 8'h00, 8'hff);
      queue_event(OP_SEND, 8'h00, 8'h00);
      queue_event(OP_QUERY, 8'hff, 8'hff);
      queue_event(OP_MOD_RELEASE, 8'h00, 8'h80);
      queue_event(OP_QUERY, 8'h00, 8'h00);
      queue_event(OP_SPARE_6, 8'hff, 8'hff);
      queue_event(OP_SPARE_7, 8'h00, 8'h00);
      wait_drained();

      write_enable(1'b0);
      queue_random(150);
      wait_drained();

      write_enable(1'b1);
      queue_random(480);
      wait_drained();

      write_enable(1'b0);
      queue_random(100);
      wait_drained();

      write_enable(1'b1);
      queue_random(200);
      wait_drained();

      if (failures == 0 && awaited_results.size() == 0)
         $display("PASS keyboard_report_aggregator_top");
      else
         $display("FAIL keyboard_report_aggregator_top");
      $finish;
   end

endmodule
